@@ rtl/cms_pkg.sv @@
// cms_pkg: shared types and constants for the constraint matrix stamp block
// holds the channel payload structs, the internal command struct and the code enums
// no dependencies
package cms_pkg;

  localparam int POINT_W = 12;
  localparam int CONS_W = 13;
  localparam int WEIGHT_W = 16;
  localparam int STIFF_W = 16;
  localparam int ROW_W = 14;
  localparam int COL_W = 15;
  localparam int VALUE_W = 32;
  localparam int BLK_W = 4;
  localparam int COMP_W = 2;

  // input mode codes
  localparam logic [1:0] MODE_STRAIN_L = 2'd0;
  localparam logic [1:0] MODE_STRAIN_R = 2'd1;
  localparam logic [1:0] MODE_BEND = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // last block number of each stamp kind, and last component
  localparam logic [BLK_W-1:0] LAST_BLK_STRAIN_L = 4'd3;
  localparam logic [BLK_W-1:0] LAST_BLK_STRAIN_R = 4'd1;
  localparam logic [BLK_W-1:0] LAST_BLK_BEND = 4'd15;
  localparam logic [COMP_W-1:0] COMP_LAST = 2'd2;

  typedef enum logic [1:0] {
    KIND_STRAIN_L,
    KIND_STRAIN_R,
    KIND_BEND
  } cmd_kind_t;

  typedef enum logic [1:0] {
    VAL_POS,
    VAL_NEG,
    VAL_BEND
  } val_kind_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [POINT_W-1:0] point_a;
    logic [POINT_W-1:0] point_b;
    logic [POINT_W-1:0] point_c;
    logic [POINT_W-1:0] point_d;
    logic [CONS_W-1:0] constraint_index;
    logic signed [WEIGHT_W-1:0] weight_a;
    logic signed [WEIGHT_W-1:0] weight_b;
    logic signed [WEIGHT_W-1:0] weight_c;
    logic signed [WEIGHT_W-1:0] weight_d;
    logic [STIFF_W-1:0] stiffness;
  } cons_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] col_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic last;
  } triplet_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [BLK_W-1:0] last_blk;
    logic [POINT_W-1:0] pa;
    logic [POINT_W-1:0] pb;
    logic [POINT_W-1:0] pc;
    logic [POINT_W-1:0] pd;
    logic [CONS_W-1:0] k;
    logic signed [WEIGHT_W-1:0] wa;
    logic signed [WEIGHT_W-1:0] wb;
    logic signed [WEIGHT_W-1:0] wc;
    logic signed [WEIGHT_W-1:0] wd;
    logic [STIFF_W-1:0] stiff;
  } cmd_t;

endpackage

@@ rtl/cms_front.sv @@
// cms_front: decodes an incoming constraint into a stamp command
// drops the unused mode, sets the last block number per stamp kind
// depends on cms_pkg
module cms_front import cms_pkg::*; (
  input  logic  item_valid,
  input  cons_t item,
  output logic  cmd_valid,
  output cmd_t  cmd
);

  always_comb begin
    cmd.pa = item.point_a;
    cmd.pb = item.point_b;
    cmd.pc = item.point_c;
    cmd.pd = item.point_d;
    cmd.k = item.constraint_index;
    cmd.wa = item.weight_a;
    cmd.wb = item.weight_b;
    cmd.wc = item.weight_c;
    cmd.wd = item.weight_d;
    cmd.stiff = item.stiffness;
    cmd_valid = item_valid;
    unique case (item.mode)
      MODE_STRAIN_L: begin
        cmd.kind = KIND_STRAIN_L;
        cmd.last_blk = LAST_BLK_STRAIN_L;
      end
      MODE_STRAIN_R: begin
        cmd.kind = KIND_STRAIN_R;
        cmd.last_blk = LAST_BLK_STRAIN_R;
      end
      MODE_BEND: begin
        cmd.kind = KIND_BEND;
        cmd.last_blk = LAST_BLK_BEND;
      end
      MODE_NONE: begin
        // no triplets: take the transfer and forget it
        cmd.kind = KIND_STRAIN_L;
        cmd.last_blk = LAST_BLK_STRAIN_L;
        cmd_valid = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/cms_queue.sv @@
// cms_queue: two-entry command queue between decode and triplet generation
// depends on cms_pkg
module cms_queue import cms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmd_t       push_cmd,
  output logic       full,
  output logic       head_valid,
  output cmd_t       head,
  input  logic       pop,
  output logic [1:0] count
);

  cmd_t mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] cnt;
  logic do_push;

  assign full = (cnt == 2'd2);
  assign head_valid = (cnt != 2'd0);
  assign head = mem[rd_ptr];
  assign count = cnt;
  assign do_push = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/cms_back.sv @@
// cms_back: walks the head command block by block and component by component
// stage a picks indices and the weight product, stage b scales and forms the triplet
// depends on cms_pkg
module cms_back import cms_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     head_valid,
  input  cmd_t     head,
  output logic     pop,
  output logic     triplet_valid,
  input  logic     triplet_stall,
  output triplet_t triplet,
  output logic     busy
);

  logic en;
  logic [BLK_W-1:0] blk;
  logic [COMP_W-1:0] comp;
  logic final_gen;

  logic [POINT_W-1:0] g_row;
  logic [CONS_W-1:0] g_col;
  val_kind_t g_vkind;
  logic signed [WEIGHT_W-1:0] g_wi;
  logic signed [WEIGHT_W-1:0] g_wj;
  logic signed [2*WEIGHT_W-1:0] g_wprod;

  logic a_valid;
  logic [POINT_W-1:0] a_row_blk;
  logic [CONS_W-1:0] a_col_blk;
  logic [COMP_W-1:0] a_comp;
  val_kind_t a_vkind;
  logic signed [2*WEIGHT_W-1:0] a_wprod;
  logic [STIFF_W-1:0] a_stiff;
  logic a_last;

  logic signed [2*WEIGHT_W+STIFF_W:0] bend_full;
  logic [VALUE_W-1:0] pos_val;
  triplet_t o_next;
  logic o_valid;
  triplet_t o_data;

  function automatic logic [POINT_W-1:0] pt_sel(input cmd_t c, input logic [1:0] i);
    logic [POINT_W-1:0] r;
    unique case (i)
      2'd0: r = c.pa;
      2'd1: r = c.pb;
      2'd2: r = c.pc;
      2'd3: r = c.pd;
    endcase
    return r;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] w_sel(input cmd_t c, input logic [1:0] i);
    logic signed [WEIGHT_W-1:0] r;
    unique case (i)
      2'd0: r = c.wa;
      2'd1: r = c.wb;
      2'd2: r = c.wc;
      2'd3: r = c.wd;
    endcase
    return r;
  endfunction

  assign en = !o_valid || !triplet_stall;
  assign final_gen = (blk == head.last_blk) && (comp == COMP_LAST);
  assign pop = en && head_valid && final_gen;
  assign busy = a_valid;

  // indices, value kind and weight product of the current block
  always_comb begin
    g_wi = w_sel(head, blk[3:2]);
    g_wj = w_sel(head, blk[1:0]);
    g_wprod = g_wi * g_wj;
    unique case (head.kind)
      KIND_STRAIN_L: begin
        unique case (blk[1:0])
          2'd0: begin
            g_row = head.pa;
            g_col = {1'b0, head.pa};
            g_vkind = VAL_POS;
          end
          2'd1: begin
            g_row = head.pb;
            g_col = {1'b0, head.pb};
            g_vkind = VAL_POS;
          end
          2'd2: begin
            g_row = head.pa;
            g_col = {1'b0, head.pb};
            g_vkind = VAL_NEG;
          end
          2'd3: begin
            g_row = head.pb;
            g_col = {1'b0, head.pa};
            g_vkind = VAL_NEG;
          end
        endcase
      end
      KIND_STRAIN_R: begin
        g_row = blk[0] ? head.pb : head.pa;
        g_col = head.k;
        g_vkind = blk[0] ? VAL_POS : VAL_NEG;
      end
      KIND_BEND: begin
        g_row = pt_sel(head, blk[3:2]);
        g_col = {1'b0, pt_sel(head, blk[1:0])};
        g_vkind = VAL_BEND;
      end
      default: begin
        g_row = '0;
        g_col = '0;
        g_vkind = VAL_POS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk <= '0;
      comp <= '0;
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= head_valid;
      if (head_valid) begin
        if (comp == COMP_LAST) begin
          comp <= '0;
          blk <= final_gen ? '0 : blk + 4'd1;
        end else begin
          comp <= comp + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && head_valid) begin
      a_row_blk <= g_row;
      a_col_blk <= g_col;
      a_comp <= comp;
      a_vkind <= g_vkind;
      a_wprod <= g_wprod;
      a_stiff <= head.stiff;
      a_last <= final_gen;
    end
  end

  // product is below 2^46 in magnitude; taking bits above 16 floors it
  always_comb begin
    bend_full = a_wprod * $signed({1'b0, a_stiff});
    pos_val = {8'd0, a_stiff, 8'd0};
    o_next.row_index = {2'b00, a_row_blk} + {1'b0, a_row_blk, 1'b0} + ROW_W'(a_comp);
    o_next.col_index = {2'b00, a_col_blk} + {1'b0, a_col_blk, 1'b0} + COL_W'(a_comp);
    o_next.last = a_last;
    unique case (a_vkind)
      VAL_POS: o_next.entry_value = pos_val;
      VAL_NEG: o_next.entry_value = -pos_val;
      VAL_BEND: o_next.entry_value = bend_full[VALUE_W+15:16];
      default: o_next.entry_value = pos_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && a_valid) begin
      o_data <= o_next;
    end
  end

  assign triplet_valid = o_valid;
  assign triplet = o_data;

endmodule

@@ rtl/constraint_matrix_stamp_top.sv @@
// constraint_matrix_stamp_top: expands one constraint into its sparse matrix triplets
// depends on cms_pkg, cms_front, cms_queue, cms_back
//
//   channel   signals                                 role
//   item      item_valid, item_stall, item            constraint in
//   triplet   triplet_valid, triplet_stall, triplet   (row, col, value, last) out
//
// one triplet leaves per cycle while triplet_stall is low: strain left gives 12 triplets, strain right 6,
// bending 48, set by the single generator stepping block and component; mode 3 gives no triplet
// a constraint into an empty block passes the queue, stage a and stage b registers before its first triplet
// the two-entry command queue keeps taking constraints while triplets are stalled, until it is full
// rst is synchronous; it empties the queue and both pipeline stages
module constraint_matrix_stamp_top import cms_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  cons_t    item,
  output logic     triplet_valid,
  input  logic     triplet_stall,
  output triplet_t triplet
);

  logic cmd_valid;
  cmd_t cmd;
  logic q_full;
  logic head_valid;
  cmd_t head;
  logic pop;
  logic [1:0] q_count;
  logic back_busy;

  cms_front u_front (
    .item_valid (item_valid),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  cms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .count      (q_count)
  );

  cms_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .triplet_valid (triplet_valid),
    .triplet_stall (triplet_stall),
    .triplet       (triplet),
    .busy          (back_busy)
  );

  assign item_stall = q_full;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst) q_count <= 2'd2)
    else $error("command queue count past depth");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    triplet_valid && !triplet_stall && !head_valid && !back_busy |=> !triplet_valid)
    else $error("triplet appeared with nothing in flight");

  a_reset: assert property (@(posedge clk) rst |=> !triplet_valid && q_count == 2'd0)
    else $error("state not cleared by reset");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

@@ tb/tb_constraint_matrix_stamp_top.sv @@
// tb_constraint_matrix_stamp_top: self-checking testbench for constraint_matrix_stamp_top
// predicts every (row, col, value, last) triplet of each transferred constraint and checks them
// in order; depends on cms_pkg and the block under test
`timescale 1ns / 1ps

module tb_constraint_matrix_stamp_top;
  import cms_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 200;
  localparam int MAX_PRINTS = 50;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_stall;
  cons_t    item = '0;
  logic     triplet_valid;
  logic     triplet_stall = 1'b0;
  triplet_t triplet;

  int errors = 0;
  int n_checked = 0;
  int n_items = 0;
  int n_mode[4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  constraint_matrix_stamp_top uut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .triplet_valid (triplet_valid),
    .triplet_stall (triplet_stall),
    .triplet       (triplet)
  );

  always #5 clk = ~clk;

  // expected triplets for every transferred constraint, oldest first
  class stamp_scoreboard;
    triplet_t expected_triplets[$];

    function void push_block(int rblk, int cblk, logic [VALUE_W-1:0] v);
      triplet_t t;
      int r;
      int c;
      for (int comp = 0; comp < 3; comp++) begin
        r = 3 * rblk + comp;
        c = 3 * cblk + comp;
        t.row_index = r[ROW_W-1:0];
        t.col_index = c[COL_W-1:0];
        t.entry_value = v;
        t.last = 1'b0;
        expected_triplets.insert(expected_triplets.size(), t);
      end
    endfunction

    function void note_constraint(cons_t c);
      logic [VALUE_W-1:0] pos;
      logic [VALUE_W-1:0] neg;
      int pt[4];
      longint w[4];
      longint prod;
      int first;
      first = expected_triplets.size();
      pos = {8'd0, c.stiffness, 8'd0};
      neg = -pos;
      pt[0] = c.point_a;
      pt[1] = c.point_b;
      pt[2] = c.point_c;
      pt[3] = c.point_d;
      w[0] = $signed(c.weight_a);
      w[1] = $signed(c.weight_b);
      w[2] = $signed(c.weight_c);
      w[3] = $signed(c.weight_d);
      case (c.mode)
        MODE_STRAIN_L: begin
          push_block(pt[0], pt[0], pos);
          push_block(pt[1], pt[1], pos);
          push_block(pt[0], pt[1], neg);
          push_block(pt[1], pt[0], neg);
        end
        MODE_STRAIN_R: begin
          push_block(pt[0], c.constraint_index, neg);
          push_block(pt[1], c.constraint_index, pos);
        end
        MODE_BEND: begin
          for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
              // arithmetic shift floors the Q16.32 product to Q16.16
              prod = (w[i] * w[j] * longint'(c.stiffness)) >>> 16;
              push_block(pt[i], pt[j], prod[VALUE_W-1:0]);
            end
          end
        end
        default: ;
      endcase
      if (expected_triplets.size() > first)
        expected_triplets[expected_triplets.size() - 1].last = 1'b1;
    endfunction

    function string check_triplet(triplet_t got);
      triplet_t want;
      string msg;
      if (expected_triplets.size() == 0)
        return $sformatf(" unexpected triplet row %0d col %0d value %0d",
                         got.row_index, got.col_index, got.entry_value);
      want = expected_triplets.pop_front();
      msg = "";
      if (got.row_index !== want.row_index)
        msg = {msg, $sformatf(" row got %0d want %0d", got.row_index, want.row_index)};
      if (got.col_index !== want.col_index)
        msg = {msg, $sformatf(" col got %0d want %0d", got.col_index, want.col_index)};
      if (got.entry_value !== want.entry_value)
        msg = {msg, $sformatf(" value got %0d want %0d", got.entry_value, want.entry_value)};
      if (got.last !== want.last)
        msg = {msg, $sformatf(" last got %0b want %0b", got.last, want.last)};
      return msg;
    endfunction

    function int pending();
      return expected_triplets.size();
    endfunction
  endclass

  stamp_scoreboard sb = new();

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch at triplet %0d:%s", n_checked, what);
  endtask

  function automatic cons_t mk(int mode, int a, int b, int c, int d, int k,
                               int wa, int wb, int wc, int wd, int s);
    cons_t t;
    t.mode = mode[1:0];
    t.point_a = a[POINT_W-1:0];
    t.point_b = b[POINT_W-1:0];
    t.point_c = c[POINT_W-1:0];
    t.point_d = d[POINT_W-1:0];
    t.constraint_index = k[CONS_W-1:0];
    t.weight_a = wa[WEIGHT_W-1:0];
    t.weight_b = wb[WEIGHT_W-1:0];
    t.weight_c = wc[WEIGHT_W-1:0];
    t.weight_d = wd[WEIGHT_W-1:0];
    t.stiffness = s[STIFF_W-1:0];
    return t;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'(int'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [POINT_W-1:0] pick_point();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return POINT_W'($urandom);
    endcase
  endfunction

  function automatic cons_t rand_constraint();
    cons_t t;
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 6) t.mode = MODE_STRAIN_L;
    else if (r < 12) t.mode = MODE_STRAIN_R;
    else if (r < 19) t.mode = MODE_BEND;
    else t.mode = MODE_NONE;
    t.point_a = pick_point();
    t.point_b = ($urandom_range(0, 5) == 0) ? t.point_a : pick_point();
    t.point_c = pick_point();
    t.point_d = ($urandom_range(0, 5) == 0) ? t.point_c : pick_point();
    case ($urandom_range(0, 5))
      0: t.constraint_index = '0;
      1: t.constraint_index = '1;
      default: t.constraint_index = CONS_W'($urandom);
    endcase
    t.weight_a = pick16();
    t.weight_b = pick16();
    t.weight_c = pick16();
    t.weight_d = pick16();
    t.stiffness = pick16();
    return t;
  endfunction

  // one constraint transfer after a random gap; valid stays high across back-to-back items
  task automatic send_constraint(cons_t c);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= c;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_constraint(c);
    n_items++;
    n_mode[c.mode]++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // mode 3 leaves nothing to wait for, so just let the pipeline settle
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // receiver: random stall before each triplet transfer
  initial begin
    int unsigned n;
    @(negedge rst);
    forever begin
      n = rx_quiet ? 0 : $urandom_range(0, 17);
      if (n > 0) begin
        triplet_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      triplet_stall <= 1'b0;
      do @(posedge clk); while (!(triplet_valid && !triplet_stall));
    end
  end

  always @(posedge clk) begin : monitor
    string msg;
    if (!rst && triplet_valid && !triplet_stall) begin
      msg = sb.check_triplet(triplet);
      if (msg != "") report_mismatch(msg);
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (triplet_valid && !triplet_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d triplets outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    cons_t c;
    int counted;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, each mode, floor rounding of negative products, unused mode
    send_constraint(mk(MODE_STRAIN_L, 0, 4095, 4095, 4095, 8191, -1, -1, -1, -1, 65535));
    send_constraint(mk(MODE_STRAIN_L, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0));
    send_constraint(mk(MODE_STRAIN_L, 4095, 0, 123, 456, 77, 32767, -32768, 5, 9, 1));
    send_constraint(mk(MODE_STRAIN_R, 0, 4095, 0, 0, 8191, 0, 0, 0, 0, 65535));
    send_constraint(mk(MODE_STRAIN_R, 4095, 0, 4095, 4095, 0, -1, -1, -1, -1, 32768));
    send_constraint(mk(MODE_STRAIN_R, 4095, 4095, 1, 2, 8191, 1, 2, 3, 4, 1));
    send_constraint(mk(MODE_STRAIN_R, 17, 3000, 9, 9, 4096, 0, 0, 0, 0, 0));
    send_constraint(mk(MODE_BEND, 0, 4095, 0, 4095, 0,
                       -32768, -32768, -32768, -32768, 65535));
    send_constraint(mk(MODE_BEND, 4095, 0, 4095, 0, 8191,
                       32767, -32768, 32767, -32768, 65535));
    send_constraint(mk(MODE_BEND, 1, 2, 3, 4, 0, 0, 0, 0, 0, 65535));
    send_constraint(mk(MODE_BEND, 4095, 4095, 4095, 4095, 8191, -1, 1, -1, 1, 1));
    send_constraint(mk(MODE_BEND, 10, 20, 30, 40, 0, -3, 7, 255, -4096, 3));
    send_constraint(mk(MODE_BEND, 100, 200, 300, 400, 5, 4096, -4096, 12345, -999, 0));
    send_constraint(mk(MODE_BEND, 0, 0, 0, 0, 0, 32767, 32767, 32767, 32767, 32768));
    send_constraint(mk(MODE_NONE, 4095, 4095, 4095, 4095, 8191, -1, -1, -1, -1, 65535));
    send_constraint(mk(MODE_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_constraint(mk(MODE_STRAIN_L, 1, 2, 0, 0, 0, 0, 0, 0, 0, 256));
    send_constraint(mk(MODE_NONE, 5, 6, 7, 8, 9, 1, 2, 3, 4, 5));
    send_constraint(mk(MODE_STRAIN_R, 2048, 2047, 0, 0, 4095, 0, 0, 0, 0, 255));
    wait_drained();

    // random part, in phases with and without idling on either side
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 25 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      c = rand_constraint();
      send_constraint(c);
      if (c.mode != MODE_NONE) begin
        counted++;
        if (counted % 80 == 0) wait_drained();
      end
    end
    item_valid <= 1'b0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d constraints (strain left %0d, strain right %0d, bending %0d, unused %0d)",
             n_items, n_mode[0], n_mode[1], n_mode[2], n_mode[3]);
    $display("checked %0d triplets, %0d mismatches", n_checked, errors);
    if (errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cms_pkg.sv
rtl/cms_front.sv
rtl/cms_queue.sv
rtl/cms_back.sv
rtl/constraint_matrix_stamp_top.sv
tb/tb_constraint_matrix_stamp_top.sv
